// ----- sv/fbfha_pkg.sv -----
// fbfha_pkg: shared types and codes for the first/best fit heap allocator
// used by the controller, the datapath, the top level and the checker
// no dependencies
package fbfha_pkg;

    // fixed field widths of the request and result beats
    localparam int REQ_W    = 11;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 2;

    // operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // placement policy codes
    localparam logic STRAT_FIRST = 1'b0;
    localparam logic STRAT_BEST  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic clear;      // write one reset entry, advance sweep counter
        logic accept;     // latch a request beat, restart the scan
        logic scan_step;  // issue next granule read, evaluate previous one
        logic free_rd;    // read the entry named by the free address
        logic free_wr;    // mark that entry free if it is an allocated block
        logic split_wr;   // write the remainder block when the pick is split
        logic pick_wr;    // write the picked block as allocated
        logic load_out;   // load the result into the output register
    } fbfha_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic clear_last;   // sweep is at the last granule
        logic in_free;      // incoming beat is a free request
        logic free_pre_ok;  // free address is non-null, aligned and in range
        logic scan_done;    // search over the block table has finished
    } fbfha_stat_t;

endpackage

// ----- sv/fbfha_ram.sv -----
// fbfha_ram: generic simple dual port ram, one write and one read port
// read data registered, held while no read is issued
// no dependencies
module fbfha_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk) begin
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/fbfha_ctrl.sv -----
// fbfha_ctrl: sequencing state machine of the heap allocator
// drives fbfha_cmd_t to the datapath and owns the handshake flags
// depends on fbfha_pkg
module fbfha_ctrl
    import fbfha_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  fbfha_stat_t stat,
    output fbfha_cmd_t  cmd
);

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_FREE_RD  = 8'b0000_0100,
        S_FREE_CHK = 8'b0000_1000,
        S_SCAN     = 8'b0001_0000,
        S_SPLIT_WR = 8'b0010_0000,
        S_PICK_WR  = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = m_valid_reg;

    // next state and command decode
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (stat.clear_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = stat.in_free ? S_FREE_RD : S_SCAN;
                end
            end
            S_FREE_RD: begin
                if (stat.free_pre_ok) begin
                    cmd.free_rd = 1'b1;
                    state_next  = S_FREE_CHK;
                end else begin
                    state_next  = S_DONE;
                end
            end
            S_FREE_CHK: begin
                cmd.free_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN: begin
                cmd.scan_step = 1'b1;
                if (stat.scan_done) begin
                    state_next = S_SPLIT_WR;
                end
            end
            S_SPLIT_WR: begin
                cmd.split_wr = 1'b1;
                state_next   = S_PICK_WR;
            end
            S_PICK_WR: begin
                cmd.pick_wr = 1'b1;
                state_next  = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output valid flag
    always_comb begin
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ----- sv/fbfha_dpath.sv -----
// fbfha_dpath: block table memory, granule scan, fit compare and result register
// acts on fbfha_cmd_t from the controller, reports fbfha_stat_t
// depends on fbfha_pkg and fbfha_ram
module fbfha_dpath
    import fbfha_pkg::*;
#(
    parameter int HEAP_BYTES   = 1024,
    parameter int HEADER_BYTES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_operation,
    input  logic [REQ_W-1:0]    s_request_size,
    input  logic [ADDR_W-1:0]   s_block_address,
    input  logic                cfg_valid,
    input  logic                cfg_strategy,
    input  fbfha_cmd_t          cmd,
    output fbfha_stat_t         stat,
    output logic [ADDR_W-1:0]   m_payload_address,
    output logic [STATUS_W-1:0] m_status
);

    localparam int GRANULES  = HEAP_BYTES / 8;
    localparam int HDR_B     = ((HEADER_BYTES + 7) / 8) * 8;
    localparam int G_W       = $clog2(GRANULES);
    localparam int CNT_W     = $clog2(GRANULES + 1);
    localparam int SIZE_W    = $clog2(HEAP_BYTES + 1);
    localparam int E_W       = SIZE_W + 2;
    localparam int S_W       = REQ_W + 1;
    localparam int CMP_W     = ((SIZE_W > S_W) ? SIZE_W : S_W) + 1;
    localparam int NG_W      = CMP_W + 1;
    localparam int PA_W      = ((G_W + 4) > ADDR_W) ? (G_W + 4) : ADDR_W;
    localparam int FG_W      = ((G_W > 7) ? G_W : 7) + 1;
    localparam int INIT_SIZE = GRANULES * 8 - HDR_B;

    // table entry layout: start, free, payload size
    localparam int E_START = E_W - 1;
    localparam int E_FREED = E_W - 2;

    // configuration
    logic strategy_reg, strategy_next;

    // latched request
    logic              op_reg;
    logic [S_W-1:0]    s_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [S_W-1:0]    s_round;

    // scan and search state
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              rd_vld_reg, rd_vld_next;
    logic [G_W-1:0]    rd_g_reg;
    logic              found_reg, found_next;
    logic [G_W-1:0]    pick_g_reg;
    logic [SIZE_W-1:0] pick_size_reg;
    logic              free_ok_reg, free_ok_next;

    // output register payload
    logic [ADDR_W-1:0]   out_addr_reg;
    logic [STATUS_W-1:0] out_status_reg;

    // memory ports
    logic             ram_we, ram_re;
    logic [G_W-1:0]   ram_waddr, ram_raddr;
    logic [E_W-1:0]   ram_wdata, ram_rdata;

    // decoded read data and derived values
    logic              rd_start, rd_freed;
    logic [SIZE_W-1:0] rd_size;
    logic [CMP_W-1:0]  t_w;
    logic              issue, cand, take, split, ng_ok;
    logic [NG_W-1:0]   ng;
    logic [SIZE_W-1:0] rest;
    logic [PA_W-1:0]   pay_wide;
    logic [ADDR_W-1:0] off;
    logic [FG_W-1:0]   free_g;
    logic              free_hit;

    fbfha_ram #(
        .WIDTH (E_W),
        .DEPTH (GRANULES)
    ) u_table (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_start = ram_rdata[E_START];
    assign rd_freed = ram_rdata[E_FREED];
    assign rd_size  = ram_rdata[SIZE_W-1:0];

    // request size rounded up to whole granules, plus one header
    assign s_round = (S_W'(s_request_size) + S_W'(7)) & ~S_W'(7);
    assign t_w     = CMP_W'(s_reg) + CMP_W'(HDR_B);

    // scan: one granule read per cycle, compare the one read last cycle
    assign issue = cmd.scan_step && (cnt_reg != CNT_W'(GRANULES));
    assign cand  = rd_vld_reg && rd_start && rd_freed && (CMP_W'(rd_size) >= t_w);
    assign take  = cand && (!found_reg ||
                   ((strategy_reg == STRAT_BEST) && (rd_size < pick_size_reg)));

    // split of the picked block
    assign split = (CMP_W'(pick_size_reg) != t_w);
    assign ng    = NG_W'(pick_g_reg) + NG_W'(t_w >> 3);
    assign ng_ok = ng < NG_W'(GRANULES);
    assign rest  = SIZE_W'(CMP_W'(pick_size_reg) - t_w);

    // payload byte address of the picked block
    assign pay_wide = {(PA_W - G_W)'(0), pick_g_reg} * PA_W'(8) + PA_W'(HDR_B);

    // free address decode
    assign off      = addr_reg - ADDR_W'(HDR_B);
    assign free_g   = FG_W'(off[ADDR_W-1:3]);
    assign free_hit = rd_start && !rd_freed;

    // status to the controller
    always_comb begin
        stat.clear_last  = (cnt_reg == CNT_W'(GRANULES - 1));
        stat.in_free     = (s_operation == OP_FREE);
        stat.free_pre_ok = (addr_reg != '0) && (addr_reg >= ADDR_W'(HDR_B)) &&
                           (off[2:0] == 3'b000) && (free_g < FG_W'(GRANULES));
        stat.scan_done   = (found_reg && (strategy_reg == STRAT_FIRST)) ||
                           ((cnt_reg == CNT_W'(GRANULES)) && !rd_vld_reg);
    end

    // memory read port
    always_comb begin
        ram_re    = issue || cmd.free_rd;
        ram_raddr = cmd.free_rd ? free_g[G_W-1:0] : cnt_reg[G_W-1:0];
    end

    // memory write port
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cnt_reg[G_W-1:0];
        ram_wdata = '0;
        priority if (cmd.clear) begin
            ram_we = 1'b1;
            if (cnt_reg == '0) begin
                ram_wdata = {1'b1, 1'b1, SIZE_W'(INIT_SIZE)};
            end
        end else if (cmd.split_wr) begin
            ram_we    = found_reg && split && ng_ok;
            ram_waddr = ng[G_W-1:0];
            ram_wdata = {1'b1, 1'b1, rest};
        end else if (cmd.pick_wr) begin
            ram_we    = found_reg;
            ram_waddr = pick_g_reg;
            ram_wdata = {1'b1, 1'b0, split ? SIZE_W'(s_reg) : pick_size_reg};
        end else if (cmd.free_wr) begin
            ram_we    = free_hit;
            ram_waddr = free_g[G_W-1:0];
            ram_wdata = {1'b1, 1'b1, rd_size};
        end else begin
            ram_we = 1'b0;
        end
    end

    // control next values
    always_comb begin
        strategy_next = cfg_valid ? cfg_strategy : strategy_reg;

        cnt_next = cnt_reg;
        if (cmd.accept) begin
            cnt_next = '0;
        end else if (cmd.clear || issue) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end

        rd_vld_next = issue;

        found_next = found_reg;
        if (cmd.accept) begin
            found_next = 1'b0;
        end else if (take) begin
            found_next = 1'b1;
        end

        free_ok_next = free_ok_reg;
        if (cmd.accept) begin
            free_ok_next = 1'b0;
        end else if (cmd.free_wr && free_hit) begin
            free_ok_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            strategy_reg <= STRAT_FIRST;
            cnt_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            found_reg    <= 1'b0;
            free_ok_reg  <= 1'b0;
        end else begin
            strategy_reg <= strategy_next;
            cnt_reg      <= cnt_next;
            rd_vld_reg   <= rd_vld_next;
            found_reg    <= found_next;
            free_ok_reg  <= free_ok_next;
        end
    end

    // request latch, scan address and best candidate
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg   <= s_operation;
            s_reg    <= s_round;
            addr_reg <= s_block_address;
        end
        if (issue) begin
            rd_g_reg <= cnt_reg[G_W-1:0];
        end
        if (take) begin
            pick_g_reg    <= rd_g_reg;
            pick_size_reg <= rd_size;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (op_reg == OP_ALLOC) begin
                out_addr_reg   <= found_reg ? pay_wide[ADDR_W-1:0] : '0;
                out_status_reg <= found_reg ? ST_OK : ST_NOFIT;
            end else begin
                out_addr_reg   <= '0;
                out_status_reg <= ((addr_reg == '0) || free_ok_reg) ? ST_OK : ST_INVALID;
            end
        end
    end

    assign m_payload_address = out_addr_reg;
    assign m_status          = out_status_reg;

endmodule

// ----- sv/first_best_fit_heap_allocator.sv -----
// first_best_fit_heap_allocator: top level, controller plus datapath
// depends on fbfha_pkg, fbfha_ctrl, fbfha_dpath, fbfha_ram
//
// Usage
//   Request channel (s_valid/s_ready): one beat per allocate or free request.
//   Allocate rounds s_request_size up to 8 bytes and places the block by the
//   strategy register; free takes the payload byte address in s_block_address.
//   Result channel (m_valid/m_ready): one beat per request with the payload
//   address and a status code.
//   Config channel (cfg_valid/cfg_ready): writes the strategy bit, 0 first fit,
//   1 best fit; always ready. The user must write it only while no request
//   is in flight; the block itself does not enforce this.
// Timing
//   Allocate reads the table one granule per cycle through the memory's read
//   port; first fit stops early when a block fits. Free reads the named entry
//   and marks it free, or skips both for an invalid address. One request is
//   in flight at a time; the next is taken in the cycle after a result loads.
// Reset and stalls
//   After reset a clearing pass writes every table entry while s_ready stays
//   low; config writes are taken during it.
//   A stalled result sits in the output register; the next request is still
//   accepted and runs, and waits for that register before it is shown.
module first_best_fit_heap_allocator
    import fbfha_pkg::*;
#(
    parameter int HEAP_BYTES   = 1024,
    parameter int HEADER_BYTES = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_operation,
    input  logic [REQ_W-1:0]    s_request_size,
    input  logic [ADDR_W-1:0]   s_block_address,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [ADDR_W-1:0]   m_payload_address,
    output logic [STATUS_W-1:0] m_status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_strategy
);

    fbfha_cmd_t  cmd;
    fbfha_stat_t stat;

    // config register always takes its beat
    assign cfg_ready = 1'b1;

    fbfha_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    fbfha_dpath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dpath (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_operation       (s_operation),
        .s_request_size    (s_request_size),
        .s_block_address   (s_block_address),
        .cfg_valid         (cfg_valid),
        .cfg_strategy      (cfg_strategy),
        .cmd               (cmd),
        .stat              (stat),
        .m_payload_address (m_payload_address),
        .m_status          (m_status)
    );

endmodule

// ----- sv/fbfha_checker.sv -----
// fbfha_checker: port level assertions for the heap allocator, bound to the top
// depends on fbfha_pkg and first_best_fit_heap_allocator
module fbfha_checker
    import fbfha_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input logic [ADDR_W-1:0]   m_payload_address,
    input logic [STATUS_W-1:0] m_status
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_payload_address) && $stable(m_status))
        else $error("result beat changed while stalled");

    // one request in flight: no accept in the cycle after an accept
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted back to back");

    // failed requests (no fit, invalid free) carry a null address
    a_fail_null: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_NOFIT || m_status == ST_INVALID) |->
        m_payload_address == '0)
        else $error("failed request returned an address");

    // payload addresses sit on granule boundaries, status code is defined
    a_addr_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_payload_address[2:0] == 3'b000 &&
        (m_status == ST_OK || m_status == ST_NOFIT || m_status == ST_INVALID))
        else $error("misaligned address or undefined status");

endmodule

bind first_best_fit_heap_allocator fbfha_checker u_fbfha_checker (.*);
